>>> design/glcm_pkg.sv
// ----------------------------------------------------------------------------
// glcm_pkg
// shared types, codes and constants of the grey level co-occurrence block
// ----------------------------------------------------------------------------
package glcm_pkg;

	// default sizes
	localparam int GREY_LEVELS_DEF = 256;
	localparam int MAX_WIDTH_DEF   = 1024;
	localparam int DIRECTIONS_DEF  = 3;

	// fixed field widths
	localparam int CNT_W      = 8;
	localparam int TOT_W      = 32;
	localparam int GREY_W     = 8;
	localparam int OP_W       = 2;
	localparam int DIR_W      = 2;
	localparam int FW_W       = 11;
	localparam int DC_W       = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// register reset values
	localparam logic [FW_W-1:0] FW_RESET  = 11'd1024;
	localparam logic [DC_W-1:0] DC_RESET  = 2'd3;
	localparam logic            SYM_RESET = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_PIXEL = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH = 2'd0,
		CFG_DIR_COUNT   = 2'd1,
		CFG_SYMMETRIC   = 2'd2
	} cfg_idx_t;

	// per-cycle command to one count table
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_zero;
		logic fwd;
	} bank_ctl_t;

endpackage

>>> design/glcm_line_buf.sv
// ----------------------------------------------------------------------------
// glcm_line_buf
// one row of grey levels, one write and one registered read port
// ----------------------------------------------------------------------------
module glcm_line_buf
	import glcm_pkg::*;
#(
	parameter int DEPTH  = MAX_WIDTH_DEF,
	parameter int DATA_W = GREY_W
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_W-1:0]        wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_W-1:0]        rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/glcm_count_bank.sv
// ----------------------------------------------------------------------------
// glcm_count_bank
// one co-occurrence table with saturating read-modify-write and clearing
// ----------------------------------------------------------------------------
module glcm_count_bank
	import glcm_pkg::*;
#(
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  bank_ctl_t         ctl,
	input  logic [ADDR_W-1:0] rd_addr,
	input  logic [ADDR_W-1:0] wr_addr,
	output logic [CNT_W-1:0]  rd_data
);

	logic [CNT_W-1:0] mem [2**ADDR_W];
	logic [CNT_W-1:0] rd_q;
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] src;
	logic [CNT_W-1:0] wdata;

	// forwarding covers a read that raced the write of the same entry
	assign src   = ctl.fwd ? last_q : rd_q;
	assign wdata = ctl.wr_zero ? '0 : ((src == '1) ? src : src + 1'b1);
	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wdata;
			last_q       <= wdata;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

endmodule

>>> design/glcm_texture_accumulator.sv
// ----------------------------------------------------------------------------
// glcm_texture_accumulator
// grey level co-occurrence counts for horizontal, vertical, diagonal pairs
// ----------------------------------------------------------------------------
//  channel   | handshake                 | beat
//  ----------+---------------------------+-----------------------------------
//  command   | start / busy              | op, grey, frame_start, read_dir,
//            |                           | read_first, read_second
//  result    | done (one-cycle strobe)   | entry_count, pair_total
//  config    | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  a pixel beat passes S_LINE, S_B1 and, in symmetric mode, S_B2 before
//  the next accept: line buffer read, then one read-modify-write per pair
//  on each table's single write port
//  a read beat passes through S_RD; done comes in the cycle after accept
//  a clear beat, and reset, sweep every table one entry a cycle over the
//  whole 2*clog2(GREY_LEVELS)-bit address space with busy high
//  config writes are taken at any time; results cannot be stalled
// ----------------------------------------------------------------------------
module glcm_texture_accumulator
	import glcm_pkg::*;
#(
	parameter int GREY_LEVELS = GREY_LEVELS_DEF,
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int DIRECTIONS  = DIRECTIONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command
	input  logic                  start,
	output logic                  busy,
	input  logic [OP_W-1:0]       op,
	input  logic [GREY_W-1:0]     grey,
	input  logic                  frame_start,
	input  logic [DIR_W-1:0]      read_dir,
	input  logic [GREY_W-1:0]     read_first,
	input  logic [GREY_W-1:0]     read_second,
	// result
	output logic                  done,
	output logic [CNT_W-1:0]      entry_count,
	output logic [TOT_W-1:0]      pair_total,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int GW   = $clog2(GREY_LEVELS);
	localparam int AW   = 2 * GW;
	localparam int COLW = $clog2(MAX_WIDTH);
	localparam int CWR  = $clog2(MAX_WIDTH + 1);
	localparam int CW   = (CWR > FW_W) ? CWR : FW_W;
	localparam logic [GREY_W:0] GREY_LIM  = (GREY_W + 1)'(GREY_LEVELS);
	localparam logic [GW-1:0]   GREY_TOP  = GW'(GREY_LEVELS - 1);
	localparam logic [CW-1:0]   WIDTH_MAX = CW'(MAX_WIDTH);

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_LINE = 6'b000100,
		S_B1   = 6'b001000,
		S_B2   = 6'b010000,
		S_RD   = 6'b100000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [FW_W-1:0] frame_width_q;
	logic [DC_W-1:0] dir_count_q;
	logic            sym_q;

	// pixel position and neighbours
	logic [COLW-1:0] col_q;
	logic            first_row_q;
	logic [GW-1:0]   prev_q;
	logic [GW-1:0]   ul_q;

	// current pixel in flight
	logic [GW-1:0]   g_q;
	logic [COLW-1:0] pcol_q;
	logic            pfirst_q;
	logic [GW-1:0]   pa_q [DIRECTIONS];
	logic [DIRECTIONS-1:0] en_q;

	// read beat
	logic [DIR_W-1:0] rdir_q;
	logic             ridx_ok_q;

	// clear sweep and totals
	logic [AW-1:0]    clr_idx_q;
	logic [TOT_W-1:0] tot_q [DIRECTIONS];

	logic            accept;
	logic [GW-1:0]   g_in;
	logic            first_in;
	logic [COLW-1:0] col_in;
	logic [CW-1:0]   width_eff;
	logic [DC_W-1:0] dc_eff;
	logic [GW-1:0]   lb_rdata;
	logic [GW-1:0]   a_now [DIRECTIONS];
	logic [DIRECTIONS-1:0] en_now;

	bank_ctl_t     bank_ctl  [DIRECTIONS];
	logic [AW-1:0] bank_raddr [DIRECTIONS];
	logic [AW-1:0] bank_waddr [DIRECTIONS];
	logic [CNT_W-1:0] bank_rdata [DIRECTIONS];

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// saturate out-of-range levels, clamp the width into 1..MAX_WIDTH
	assign g_in = ({1'b0, grey} >= GREY_LIM) ? GREY_TOP : grey[GW-1:0];
	assign first_in = frame_start ? 1'b1 : first_row_q;
	assign col_in   = frame_start ? '0 : col_q;
	assign dc_eff   = (dir_count_q == '0) ? DC_W'(1) : dir_count_q;

	always_comb begin
		width_eff = CW'(frame_width_q);
		if (width_eff == '0) begin
			width_eff = CW'(1);
		end else if (width_eff > WIDTH_MAX) begin
			width_eff = WIDTH_MAX;
		end
	end

	// neighbour of each direction and whether its pair exists
	always_comb begin
		for (int d = 0; d < DIRECTIONS; d++) begin
			if (d == 0) begin
				a_now[d]  = prev_q;
				en_now[d] = (pcol_q != '0);
			end else if (d == 1) begin
				a_now[d]  = lb_rdata;
				en_now[d] = !pfirst_q && (dc_eff >= DC_W'(2));
			end else begin
				a_now[d]  = ul_q;
				en_now[d] = !pfirst_q && (dc_eff >= DC_W'(3)) && (pcol_q != '0);
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q <= FW_RESET;
			dir_count_q   <= DC_RESET;
			sym_q         <= SYM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: frame_width_q <= cfg_data[FW_W-1:0];
				CFG_DIR_COUNT:   dir_count_q   <= cfg_data[DC_W-1:0];
				CFG_SYMMETRIC:   sym_q         <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_idx_q   <= '0;
			col_q       <= '0;
			first_row_q <= 1'b1;
			prev_q      <= '0;
			ul_q        <= '0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (op)
							OP_PIXEL: begin
								state_q <= S_LINE;
								// advance the position now; neighbours follow in S_LINE
								if ((CW'(col_in) + CW'(1)) >= width_eff) begin
									col_q       <= '0;
									first_row_q <= 1'b0;
								end else begin
									col_q       <= col_in + 1'b1;
									first_row_q <= first_in;
								end
							end
							OP_CLEAR: begin
								state_q   <= S_CLR;
								clr_idx_q <= '0;
							end
							OP_READ: state_q <= S_RD;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_LINE: begin
					prev_q  <= g_q;
					ul_q    <= lb_rdata;
					state_q <= S_B1;
				end
				S_B1: state_q <= sym_q ? S_B2 : S_IDLE;
				S_B2: state_q <= S_IDLE;
				S_RD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload of the beat in flight
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			g_q       <= g_in;
			pcol_q    <= col_in;
			pfirst_q  <= first_in;
			rdir_q    <= read_dir;
			ridx_ok_q <= ({1'b0, read_first} < GREY_LIM) && ({1'b0, read_second} < GREY_LIM);
		end
		if (state_q == S_LINE) begin
			for (int d = 0; d < DIRECTIONS; d++) begin
				pa_q[d] <= a_now[d];
			end
			en_q <= en_now;
		end
	end

	// per-direction totals, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < DIRECTIONS; d++) begin
				tot_q[d] <= '0;
			end
		end else if (state_q == S_IDLE && accept && op == OP_CLEAR) begin
			for (int d = 0; d < DIRECTIONS; d++) begin
				tot_q[d] <= '0;
			end
		end else if (state_q == S_B1 || state_q == S_B2) begin
			for (int d = 0; d < DIRECTIONS; d++) begin
				if (en_q[d] && tot_q[d] != '1) begin
					tot_q[d] <= tot_q[d] + 1'b1;
				end
			end
		end
	end

	// table commands: read (a,b) in S_LINE, write it and read (b,a) in S_B1,
	// write (b,a) in S_B2, forwarding if a equals b; zero in S_CLR, read on accept
	always_comb begin
		for (int d = 0; d < DIRECTIONS; d++) begin
			bank_ctl[d].rd_en   = (state_q == S_LINE)
				|| (state_q == S_B1 && sym_q)
				|| (state_q == S_IDLE && accept && op == OP_READ);
			bank_ctl[d].wr_en   = (state_q == S_CLR)
				|| ((state_q == S_B1 || state_q == S_B2) && en_q[d]);
			bank_ctl[d].wr_zero = (state_q == S_CLR);
			bank_ctl[d].fwd     = (state_q == S_B2) && (pa_q[d] == g_q);
			case (state_q)
				S_LINE:  bank_raddr[d] = {a_now[d], g_q};
				S_B1:    bank_raddr[d] = {g_q, pa_q[d]};
				default: bank_raddr[d] = {read_first[GW-1:0], read_second[GW-1:0]};
			endcase
			case (state_q)
				S_B1:    bank_waddr[d] = {pa_q[d], g_q};
				S_B2:    bank_waddr[d] = {g_q, pa_q[d]};
				default: bank_waddr[d] = clr_idx_q;
			endcase
		end
	end

	for (genvar d = 0; d < DIRECTIONS; d++) begin : g_bank
		glcm_count_bank #(
			.ADDR_W (AW)
		) u_bank (
			.clk     (clk),
			.ctl     (bank_ctl[d]),
			.rd_addr (bank_raddr[d]),
			.wr_addr (bank_waddr[d]),
			.rd_data (bank_rdata[d])
		);
	end

	glcm_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (GW)
	) u_line (
		.clk     (clk),
		.wr_en   (state_q == S_LINE),
		.wr_addr (pcol_q),
		.wr_data (g_q),
		.rd_en   (state_q == S_IDLE && accept && op == OP_PIXEL),
		.rd_addr (col_in),
		.rd_data (lb_rdata)
	);

	// result: shown for the single S_RD cycle
	assign done = (state_q == S_RD);

	always_comb begin
		entry_count = '0;
		pair_total  = '0;
		for (int d = 0; d < DIRECTIONS; d++) begin
			if (rdir_q == DIR_W'(d)) begin
				pair_total = tot_q[d];
				if (ridx_ok_q) begin
					entry_count = bank_rdata[d];
				end
			end
		end
	end

endmodule

>>> design/glcm_checker.sv
// ----------------------------------------------------------------------------
// glcm_checker
// port-level checks of the command and result channels
// ----------------------------------------------------------------------------
module glcm_checker
	import glcm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [OP_W-1:0]   op,
	input logic [DIR_W-1:0]  read_dir,
	input logic              done,
	input logic [CNT_W-1:0]  entry_count,
	input logic [TOT_W-1:0]  pair_total
);

	// a read beat answers in the next cycle
	a_read_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_READ) |=> done)
		else $error("read beat gave no result");

	// results only come from a read in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// a strobe lasts one cycle
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held");

	// direction three is never a table
	a_bad_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_READ && read_dir == 2'd3)
			|=> (entry_count == '0 && pair_total == '0))
		else $error("bad direction read nonzero");

	// pixel beats keep the block busy while the tables update
	a_pixel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_PIXEL) |=> (busy && !done))
		else $error("pixel beat not held busy");

endmodule

bind glcm_texture_accumulator glcm_checker u_glcm_checker (.*);
